// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define FCFLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, held off during reset
`define FCFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`else

`define FCFLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/fcfla_pkg.sv -----
// Types and constants for the fixed-chunk free-list allocator.
// No dependencies; used by the channel interfaces and the core.
package fcfla_pkg;

  localparam int ADDR_W          = 32;
  localparam int SHIFT_W         = 5;
  localparam int COUNT_W         = 9;
  localparam int CMD_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int SHIFT_MIN       = 2;
  localparam int SHIFT_MAX       = 16;
  localparam int DEF_MAX_CHUNKS  = 256;

  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REBUILD = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_SHIFT = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_REBUILD,
    S_DONE
  } state_t;

endpackage

// ----- rtl/fcfla_if.sv -----
// Valid/ready channel interfaces for the allocator: command in, result out, config.
// Depends on fcfla_pkg for field widths.
interface fcfla_in_if import fcfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] chunk_address;

  modport source (output valid, output command, output chunk_address, input ready);
  modport sink   (input valid, input command, input chunk_address, output ready);
endinterface

interface fcfla_out_if import fcfla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output address, output status, input ready);
  modport sink   (input valid, input address, input status, output ready);
endinterface

interface fcfla_cfg_if import fcfla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/fixed_chunk_free_list_allocator_core.sv -----
// Fixed-size chunk pool with a LIFO free list held in a link RAM.
// Allocate and free pass S_ALLOC or S_FREE, then S_DONE; empty, null and unused
// commands go straight to S_DONE; rebuild writes one link a cycle in S_REBUILD up to
// the effective chunk_count, then S_DONE. Throughput: one word at a time, the next
// taken the cycle after the result loads; a stalled result register adds its wait.
// Reset (sync, active low): config to defaults, free list empty; link RAM not cleared.
`include "assert_macros.svh"

module fixed_chunk_free_list_allocator_core import fcfla_pkg::*; #(
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic             clk,
  input  logic             rst_n,
  fcfla_in_if.sink         in_ch,
  fcfla_out_if.source      out_ch,
  fcfla_cfg_if.sink        cfg_ch
);

  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int LINK_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_CHUNKS);

  // config registers
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // control
  state_t             state_r, state_nxt;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  status_t            out_status_r, out_status_nxt;

  // link RAM
  logic [LINK_W-1:0]  link_mem [MAX_CHUNKS];
  logic [LINK_W-1:0]  rd_data_r;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_wa, mem_ra;
  logic [LINK_W-1:0]  mem_wd;

  // shared adder
  logic [ADDR_W-1:0]  add_a, add_b, add_sum;
  logic               add_sub;

  logic [SHIFT_W-1:0] eff_shift;
  logic [ADDR_W-1:0]  cnt_wide;
  logic [LINK_W-1:0]  eff_cnt;
  logic               in_fire, cfg_fire, out_free;
  logic [ADDR_W-1:0]  off_mask, off_idx;
  logic               free_bad;
  logic [LINK_W-1:0]  reb_next;
  logic               reb_last;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.address = out_addr_r;
  assign out_ch.status  = out_status_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (shift_r < SHIFT_W'(SHIFT_MIN)) begin
      eff_shift = SHIFT_W'(SHIFT_MIN);
    end else if (shift_r > SHIFT_W'(SHIFT_MAX)) begin
      eff_shift = SHIFT_W'(SHIFT_MAX);
    end else begin
      eff_shift = shift_r;
    end
    cnt_wide = (ADDR_W'(count_r) > ADDR_W'(MAX_CHUNKS)) ? ADDR_W'(MAX_CHUNKS)
                                                        : ADDR_W'(count_r);
    eff_cnt  = cnt_wide[LINK_W-1:0];
  end

  // one adder serves chunk address, free offset and rebuild index
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_ALLOC: begin
        add_a = base_r;
        add_b = ADDR_W'(head_r[IDX_W-1:0]) << eff_shift;
      end
      S_FREE: begin
        add_a   = addr_r;
        add_b   = base_r;
        add_sub = 1'b1;
      end
      S_REBUILD: begin
        add_a = ADDR_W'(cnt_r);
        add_b = ADDR_W'(1);
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + ADDR_W'(add_sub);
  end

  always_comb begin
    off_mask = ~({ADDR_W{1'b1}} << eff_shift);
    off_idx  = add_sum >> eff_shift;
    free_bad = (|(add_sum & off_mask)) || (off_idx >= ADDR_W'(eff_cnt));
    reb_next = add_sum[LINK_W-1:0];
    reb_last = (reb_next == eff_cnt);
  end

  always_comb begin
    base_nxt  = base_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    if (cfg_fire) begin
      unique case (cfg_ch.index)
        CFG_BASE:  base_nxt  = cfg_ch.data;
        CFG_SHIFT: shift_nxt = cfg_ch.data[SHIFT_W-1:0];
        CFG_COUNT: count_nxt = cfg_ch.data[COUNT_W-1:0];
        default:   base_nxt  = base_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = head_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          addr_nxt       = in_ch.chunk_address;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          unique case (in_ch.command)
            CMD_ALLOC: begin
              if (head_r == LIST_END) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (in_ch.chunk_address == '0) begin
                res_status_nxt = ST_NULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FREE;
              end
            end
            CMD_REBUILD: begin
              if (eff_cnt == '0) begin
                head_nxt  = LIST_END;
                state_nxt = S_DONE;
              end else begin
                cnt_nxt   = '0;
                state_nxt = S_REBUILD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        res_addr_nxt = add_sum;
        head_nxt     = rd_data_r;
        state_nxt    = S_DONE;
      end
      S_FREE: begin
        if (free_bad) begin
          res_status_nxt = ST_BAD;
        end else begin
          mem_we   = 1'b1;
          mem_wa   = off_idx[IDX_W-1:0];
          mem_wd   = head_r;
          head_nxt = LINK_W'(off_idx[IDX_W-1:0]);
        end
        state_nxt = S_DONE;
      end
      S_REBUILD: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = reb_last ? LIST_END : reb_next;
        if (reb_last) begin
          head_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = add_sum[IDX_W-1:0];
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LIST_END;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RST;
      shift_r     <= SHIFT_RST;
      count_r     <= COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      shift_r     <= shift_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= link_mem[mem_ra];
    end
  end

  `FCFLA_ASSERT_IMPL(a_reb_in_range, clk, rst_n, state_r == S_REBUILD,
    ADDR_W'(cnt_r) < ADDR_W'(eff_cnt))
  `FCFLA_ASSERT_IMPL(a_we_states, clk, rst_n, mem_we,
    state_r == S_FREE || state_r == S_REBUILD)
  `FCFLA_ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid_r && out_status_r == ST_EMPTY,
    out_addr_r == '0)
  `FCFLA_ASSERT_NEXT(a_alloc_pop, clk, rst_n, state_r == S_ALLOC,
    head_r == $past(rd_data_r) && state_r == S_DONE)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the fixed-chunk free-list allocator core.
// Uses fcfla_pkg and the channel interfaces in fcfla_if.sv; a local pool predictor
// works out each reply as a word is accepted, and a monitor checks replies in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcfla_pkg::*;

  localparam int MAX_CHUNKS = DEF_MAX_CHUNKS;
  localparam int unsigned LIST_END = MAX_CHUNKS;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_CYCLES = 400000;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_t           status;
  } reply_t;

  logic clk;
  logic rst_n;

  fcfla_in_if  in_ch();
  fcfla_out_if out_ch();
  fcfla_cfg_if cfg_ch();

  fixed_chunk_free_list_allocator_core #(.MAX_CHUNKS(MAX_CHUNKS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // pool predictor state
  logic [ADDR_W-1:0]  pool_base;
  logic [SHIFT_W-1:0] pool_shift;
  logic [COUNT_W-1:0] pool_count;
  int unsigned        link_mem [MAX_CHUNKS];
  int unsigned        free_head;

  reply_t            replies_due[$];
  logic [ADDR_W-1:0] held_chunks[$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned grants;
  int unsigned empties;
  int unsigned null_frees;
  int unsigned rejects;
  int unsigned rebuilds;
  int unsigned reg_writes;
  int unsigned cycles;
  bit          steady;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned eff_shift();
    if (pool_shift < SHIFT_W'(SHIFT_MIN)) return SHIFT_MIN;
    if (pool_shift > SHIFT_W'(SHIFT_MAX)) return SHIFT_MAX;
    return pool_shift;
  endfunction

  function automatic int unsigned eff_count();
    if (pool_count > COUNT_W'(MAX_CHUNKS)) return MAX_CHUNKS;
    return pool_count;
  endfunction

  // advances the pool state by one command and returns its reply
  function automatic reply_t predict_reply(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    reply_t            r;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] mask;
    int unsigned       sh;
    int unsigned       cnt;
    int unsigned       idx;
    sh = eff_shift();
    cnt = eff_count();
    r.address = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        if (free_head >= LIST_END) begin
          r.status = ST_EMPTY;
        end else begin
          r.address = pool_base + (ADDR_W'(free_head) << sh);
          free_head = link_mem[free_head];
        end
      end
      CMD_FREE: begin
        if (addr == '0) begin
          r.status = ST_NULL;
        end else begin
          off = addr - pool_base;
          mask = (ADDR_W'(1) << sh) - 1;
          idx = off >> sh;
          if ((off & mask) != '0 || idx >= cnt) begin
            r.status = ST_BAD;
          end else begin
            link_mem[idx] = free_head;
            free_head = idx;
          end
        end
      end
      CMD_REBUILD: begin
        if (cnt == 0) begin
          free_head = LIST_END;
        end else begin
          for (int unsigned i = 0; i + 1 < cnt; i++) link_mem[i] = i + 1;
          link_mem[cnt - 1] = LIST_END;
          free_head = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    reply_t      r;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.chunk_address <= addr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = predict_reply(cmd, addr);
    replies_due.push_back(r);
    words_sent++;
    case (r.status)
      ST_EMPTY: empties++;
      ST_NULL:  null_frees++;
      ST_BAD:   rejects++;
      default:  if (cmd == CMD_ALLOC) grants++;
    endcase
    if (cmd == CMD_ALLOC && r.status == ST_OK && r.address != '0)
      held_chunks.push_back(r.address);
    if (cmd == CMD_REBUILD) begin
      rebuilds++;
      held_chunks.delete();
    end
  endtask

  // stop sending and wait for every reply still owed
  task automatic drain_replies();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_BASE:  pool_base = data;
      CFG_SHIFT: pool_shift = data[SHIFT_W-1:0];
      CFG_COUNT: pool_count = data[COUNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    held_chunks.delete();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // upper data bits beyond the register width are sometimes junk
  task automatic set_pool(logic [ADDR_W-1:0] base, int unsigned shift, int unsigned count);
    logic [ADDR_W-1:0] junk;
    drain_replies();
    write_reg(CFG_BASE, base);
    junk = $urandom_range(0, 1) ? ADDR_W'($urandom) : '0;
    write_reg(CFG_SHIFT, (junk << SHIFT_W) | ADDR_W'(shift));
    junk = $urandom_range(0, 1) ? ADDR_W'($urandom) : '0;
    write_reg(CFG_COUNT, (junk << COUNT_W) | ADDR_W'(count));
  endtask

  task automatic test_commands_from_reset();
    send_word(CMD_ALLOC, '0);               // empty until a rebuild
    send_word(CMD_FREE, '0);
    send_word(CMD_FREE, 32'h0000_0010);     // push before any rebuild
    send_word(CMD_ALLOC, '0);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF);
    send_word(CMD_REBUILD, '0);
    send_word(CMD_ALLOC, '0);               // chunk at zero
    send_word(CMD_FREE, 32'h0000_0018);     // misaligned
    send_word(CMD_FREE, 32'h0000_1000);     // index past count
    send_word(CMD_FREE, 32'hFFFF_FFFF);
    send_word(CMD_FREE, 32'h0000_0010);
    send_word(CMD_FREE, 32'h0000_0010);     // double free, pushed again
    send_word(CMD_ALLOC, '0);
  endtask

  task automatic test_config_extremes();
    set_pool('0, 0, 0);                     // shift saturates up, empty pool
    send_word(CMD_REBUILD, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, 32'h0000_0004);
    set_pool(32'hFFFF_0000, 31, 511);       // shift and count clamp, addresses wrap
    send_word(CMD_REBUILD, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, 32'h00FE_0000);
    send_word(CMD_FREE, 32'h00FF_0000);
    set_pool(32'h8000_0004, SHIFT_MIN, 1);
    send_word(CMD_REBUILD, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);
  endtask

  task automatic send_random_word();
    int unsigned       pick;
    int unsigned       sh;
    int unsigned       cnt;
    int unsigned       slot;
    logic [ADDR_W-1:0] a;
    sh = eff_shift();
    cnt = eff_count();
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 80 && held_chunks.size() == 0)) begin
      send_word(CMD_ALLOC, ADDR_W'($urandom));
    end else if (pick < 80) begin
      slot = $urandom_range(0, held_chunks.size() - 1);
      a = held_chunks[slot];
      held_chunks.delete(slot);
      send_word(CMD_FREE, a);
    end else if (pick < 83) begin
      send_word(CMD_REBUILD, ADDR_W'($urandom));
    end else if (pick < 86) begin
      send_word(CMD_FREE, '0);
    end else if (pick < 92) begin
      case ($urandom_range(0, 2))
        0: a = pool_base + (ADDR_W'($urandom_range(0, MAX_CHUNKS - 1)) << sh)
               + ADDR_W'($urandom_range(1, (1 << sh) - 1));
        1: a = pool_base + (ADDR_W'(cnt + $urandom_range(0, 40)) << sh);
        default: a = ADDR_W'($urandom);
      endcase
      send_word(CMD_FREE, a);
    end else if (pick < 95) begin
      send_word(CMD_UNUSED, ADDR_W'($urandom));
    end else begin
      // valid chunk that may already be on the list
      a = pool_base + (ADDR_W'($urandom_range(0, (cnt == 0) ? 0 : cnt - 1)) << sh);
      send_word(CMD_FREE, a);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_pool(ADDR_W'($urandom) & ~32'hFFF, $urandom_range(2, 16), $urandom_range(1, 12));
        1: set_pool(ADDR_W'($urandom), SHIFT_MIN, MAX_CHUNKS);
        2: set_pool(32'hFFFF_FFFC - ADDR_W'($urandom_range(0, 4095) << 2), SHIFT_MAX, 300);
        3: set_pool(ADDR_W'($urandom), $urandom_range(0, 31), $urandom_range(1, 8));
        default: set_pool('0, $urandom_range(2, 16), $urandom_range(0, 511));
      endcase
      steady = (phase == 3);
      send_word(CMD_REBUILD, '0);
      for (int n = 0; n < 80; n++) begin
        if (phase == 1 && n == 40) drain_replies();
        send_random_word();
      end
    end
    steady = 1'b0;
  endtask

  task automatic finish_run();
    drain_replies();
    repeat (MAX_CHUNKS + 16) @(posedge clk);
    $display("%0d words, %0d register writes: %0d grants, %0d empty pool, %0d rebuilds",
             words_sent, reg_writes, grants, empties, rebuilds);
    $display("frees turned away: %0d null, %0d invalid; %0d mismatches",
             null_frees, rejects, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  endtask

  // result side back-pressure
  initial begin : drive_ready
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected word, address %h status %0d", $time,
                 out_ch.address, out_ch.status);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (out_ch.address !== want.address) begin
          $display("%0t: address expected %h got %h", $time, want.address, out_ch.address);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > WATCHDOG_CYCLES) begin
      $display("%0t: timed out with %0d replies owed", $time, replies_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ALLOC;
    in_ch.chunk_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BASE;
    cfg_ch.data = '0;
    steady = 1'b0;
    errors = 0;
    cycles = 0;
    pool_base = BASE_RST;
    pool_shift = SHIFT_RST;
    pool_count = COUNT_RST;
    foreach (link_mem[i]) link_mem[i] = 0;
    free_head = LIST_END;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_commands_from_reset();
    test_config_extremes();
    test_random_traffic();
    finish_run();
  end

endmodule

// ----- fixed_chunk_free_list_allocator_core.f -----
+incdir+rtl
rtl/fcfla_pkg.sv
rtl/fcfla_if.sv
rtl/fixed_chunk_free_list_allocator_core.sv
bench/testbench.sv
